@@ sv/p2k_pkg.sv @@
// Shared types, codes and constants for the PS/2 keyboard host link.
// Used by every module of the block; depends on nothing.

package p2k_pkg;

  // Commands carried on the input channel
  localparam logic [1:0] CMD_EDGE   = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_SEND   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Data line actions
  localparam logic [1:0] LINE_KEEP    = 2'd0;
  localparam logic [1:0] LINE_LOW     = 2'd1;
  localparam logic [1:0] LINE_HIGH    = 2'd2;
  localparam logic [1:0] LINE_RELEASE = 2'd3;

  // Configuration register indexes
  localparam logic REG_GLITCH_GAP    = 1'b0;
  localparam logic REG_FRAME_TIMEOUT = 1'b1;

  localparam logic [31:0] GLITCH_GAP_RESET    = 32'd8000;
  localparam logic [31:0] FRAME_TIMEOUT_RESET = 32'd19200;

  // Scan code queue
  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Queue between front and back
  localparam int LINK_DEPTH = 2;
  localparam int LPTR_W     = $clog2(LINK_DEPTH);
  localparam int LCNT_W     = $clog2(LINK_DEPTH + 1);

  // Frame layout
  localparam logic [3:0] RX_FRAME_LEN = 4'd11;
  localparam logic [3:0] TX_LAST_POS  = 4'd9;

  // Special bytes
  localparam logic [7:0] BYTE_E0  = 8'hE0;
  localparam logic [7:0] BYTE_E1  = 8'hE1;
  localparam logic [7:0] BYTE_F0  = 8'hF0;
  localparam logic [7:0] BYTE_ACK = 8'hFA;

  typedef enum logic [1:0] {
    KIND_EDGE,
    KIND_READ,
    KIND_SEND,
    KIND_NONE
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] edge_time;
    logic        data_level;
    logic [8:0]  tx_frame;   // parity bit over data byte
  } link_item_t;

  typedef struct packed {
    logic        valid;
    logic        index;
    logic [31:0] data;
  } cfg_write_t;

endpackage

@@ sv/ps2_keyboard_host_link.sv @@
// Top level of the PS/2 keyboard host link: front decoder, link queue, back end.
// Depends on p2k_pkg, p2k_front, p2k_fifo and p2k_back.
//
//   channel | direction | handshake            | payload
//   in_     | sink      | in_tvalid/in_tready  | tdata 48 bits, tuser = command
//   out_    | source    | out_tvalid/out_tready| tdata 24 bits, one beat per input beat
//   cfg_    | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data 32 bits
//
// One beat a cycle while out_tready is high; results pass link queue and result register.
// The back end updates all link state for one item in the cycle that it pops the item.
// Reset is synchronous; the scan code queue needs no clearing pass.
// A stalled output holds the result register; the two-entry link queue lets
// the input keep accepting until it fills. Configuration writes are always taken.

module ps2_keyboard_host_link
  import p2k_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // edge_time[31:0], data_level[32], send_byte[40:33], zeros
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // line_action[1:0], read_code[17:2], read_valid[18],
                                  // ack_seen[19], tx_busy[20], overflow[21], zeros
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic       link_full;
  logic       push_valid;
  link_item_t push_item;
  logic       pop_avail;
  logic       pop;
  link_item_t pop_item;
  cfg_write_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  p2k_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .link_full  (link_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  p2k_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (link_full),
    .pop_avail  (pop_avail),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  p2k_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .item_avail (pop_avail),
    .item       (pop_item),
    .item_pop   (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sv/p2k_front.sv @@
// Front end of the PS/2 host link: decodes commands and prepares transmit frames.
// Depends on p2k_pkg.

module p2k_front
  import p2k_pkg::*;
(
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        link_full,
  output logic        push_valid,
  output link_item_t  push_item
);

  logic [7:0] send_byte;

  assign send_byte  = in_tdata[40:33];
  assign in_tready  = !link_full;
  assign push_valid = in_tvalid && !link_full;

  // Classify the beat and build the odd-parity transmit frame
  always_comb begin
    push_item.edge_time  = in_tdata[31:0];
    push_item.data_level = in_tdata[32];
    push_item.tx_frame   = {~(^send_byte), send_byte};
    unique case (in_tuser)
      CMD_EDGE:   push_item.kind = KIND_EDGE;
      CMD_READ:   push_item.kind = KIND_READ;
      CMD_SEND:   push_item.kind = KIND_SEND;
      CMD_UNUSED: push_item.kind = KIND_NONE;
      default:    push_item.kind = KIND_NONE;
    endcase
  end

endmodule

@@ sv/p2k_fifo.sv @@
// Short queue of classified items between front and back of the PS/2 host link.
// Depends on p2k_pkg.

module p2k_fifo
  import p2k_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  link_item_t push_item,
  output logic       full,
  output logic       pop_avail,
  input  logic       pop,
  output link_item_t pop_item
);

  link_item_t          mem_r [LINK_DEPTH];
  logic [LPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [LPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LCNT_W-1:0]   count_r, count_nxt;
  logic                do_pop;

  assign full      = (count_r == LCNT_W'(LINK_DEPTH));
  assign pop_avail = (count_r != '0);
  assign do_pop    = pop && pop_avail;
  assign pop_item  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == LPTR_W'(LINK_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LPTR_W'(LINK_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the beat
  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/p2k_back.sv @@
// Back end of the PS/2 host link: edge timing, receive and transmit framing,
// scan code queue, configuration registers and the result register.
// Depends on p2k_pkg.

module p2k_back
  import p2k_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_write_t  cfg_wr,
  input  logic        item_avail,
  input  link_item_t  item,
  output logic        item_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata
);

  // Configuration
  logic [31:0] glitch_r, timeout_r;

  // Link state
  logic [31:0] last_edge_r, last_edge_nxt;
  logic [10:0] rx_bits_r, rx_bits_nxt;
  logic [3:0]  rx_cnt_r, rx_cnt_nxt;
  logic [2:0]  prefix_r, prefix_nxt;
  logic        ack_r, ack_nxt;
  logic [8:0]  tx_bits_r, tx_bits_nxt;
  logic [3:0]  tx_pos_r, tx_pos_nxt;
  logic        tx_active_r, tx_active_nxt;
  logic        ovf_r, ovf_nxt;

  // Scan code queue
  logic [15:0]       code_mem_r [QUEUE_DEPTH];
  logic [QIDX_W-1:0] head_r, head_nxt;
  logic [QIDX_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] qcount_r, qcount_nxt;
  logic              code_push;
  logic [15:0]       code_new;

  // Result register
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        fire;

  // Per-item scratch
  logic [31:0] gap;
  logic [10:0] rx_bits_v;
  logic [3:0]  rx_cnt_v;
  logic [7:0]  rx_byte;
  logic        frame_ok;
  logic [1:0]  res_action;
  logic [15:0] res_code;
  logic        res_valid;

  assign fire       = item_avail && (!out_valid_r || out_tready);
  assign item_pop   = fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign gap        = item.edge_time - last_edge_r;

  // Execute one item
  always_comb begin
    last_edge_nxt = last_edge_r;
    rx_bits_nxt   = rx_bits_r;
    rx_cnt_nxt    = rx_cnt_r;
    prefix_nxt    = prefix_r;
    ack_nxt       = ack_r;
    tx_bits_nxt   = tx_bits_r;
    tx_pos_nxt    = tx_pos_r;
    tx_active_nxt = tx_active_r;
    ovf_nxt       = ovf_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    qcount_nxt    = qcount_r;
    code_push     = 1'b0;
    code_new      = '0;
    rx_bits_v     = rx_bits_r;
    rx_cnt_v      = rx_cnt_r;
    rx_byte       = '0;
    frame_ok      = 1'b0;
    res_action    = LINE_KEEP;
    res_code      = '0;
    res_valid     = 1'b0;
    if (fire) begin
      unique case (item.kind)
        KIND_EDGE: begin
          if (gap >= glitch_r) begin
            if (gap > timeout_r) begin
              rx_bits_v = '0;
              rx_cnt_v  = '0;
            end
            last_edge_nxt = item.edge_time;
            rx_bits_nxt   = rx_bits_v;
            rx_cnt_nxt    = rx_cnt_v;
            if (tx_active_r) begin
              // Shift out data and parity, then let the line go
              if (tx_pos_r >= TX_LAST_POS) begin
                tx_active_nxt = 1'b0;
                tx_bits_nxt   = '0;
                tx_pos_nxt    = '0;
                res_action    = LINE_RELEASE;
              end else begin
                res_action = tx_bits_r[tx_pos_r] ? LINE_HIGH : LINE_LOW;
                tx_pos_nxt = tx_pos_r + 4'd1;
              end
            end else begin
              // Collect the receive bit
              if (rx_cnt_v < RX_FRAME_LEN && item.data_level) begin
                rx_bits_v[rx_cnt_v] = 1'b1;
              end
              rx_cnt_v    = rx_cnt_v + 4'd1;
              rx_bits_nxt = rx_bits_v;
              rx_cnt_nxt  = rx_cnt_v;
              if (rx_cnt_v >= RX_FRAME_LEN) begin
                rx_bits_nxt = '0;
                rx_cnt_nxt  = '0;
                frame_ok    = !rx_bits_v[0] && rx_bits_v[10] && (^rx_bits_v[9:1]);
                rx_byte     = rx_bits_v[8:1];
                if (frame_ok) begin
                  case (rx_byte)
                    BYTE_E0:  prefix_nxt = prefix_r | 3'b001;
                    BYTE_E1:  prefix_nxt = prefix_r | 3'b010;
                    BYTE_F0:  prefix_nxt = prefix_r | 3'b100;
                    BYTE_ACK: ack_nxt    = 1'b1;
                    default: begin
                      code_new = {prefix_r[2], 5'd0,
                                  !prefix_r[0] && prefix_r[1], prefix_r[0], rx_byte};
                      prefix_nxt = '0;
                      if (qcount_r == QCNT_W'(QUEUE_DEPTH)) begin
                        ovf_nxt = 1'b1;
                      end else begin
                        code_push  = 1'b1;
                        tail_nxt   = (tail_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
                                     : tail_r + 1'b1;
                        qcount_nxt = qcount_r + 1'b1;
                      end
                    end
                  endcase
                end
              end
            end
          end
        end
        KIND_READ: begin
          if (qcount_r != '0) begin
            res_code   = code_mem_r[head_r];
            res_valid  = 1'b1;
            head_nxt   = (head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            qcount_nxt = qcount_r - 1'b1;
          end
        end
        KIND_SEND: begin
          tx_bits_nxt   = item.tx_frame;
          tx_pos_nxt    = '0;
          tx_active_nxt = 1'b1;
          ack_nxt       = 1'b0;
        end
        KIND_NONE: begin
          res_action = LINE_KEEP;
        end
        default: begin
          res_action = LINE_KEEP;
        end
      endcase
    end
  end

  // Control and link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glitch_r    <= GLITCH_GAP_RESET;
      timeout_r   <= FRAME_TIMEOUT_RESET;
      last_edge_r <= '0;
      rx_bits_r   <= '0;
      rx_cnt_r    <= '0;
      prefix_r    <= '0;
      ack_r       <= 1'b0;
      tx_bits_r   <= '0;
      tx_pos_r    <= '0;
      tx_active_r <= 1'b0;
      ovf_r       <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      qcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr.valid && cfg_wr.index == REG_GLITCH_GAP) begin
        glitch_r <= cfg_wr.data;
      end
      if (cfg_wr.valid && cfg_wr.index == REG_FRAME_TIMEOUT) begin
        timeout_r <= cfg_wr.data;
      end
      last_edge_r <= last_edge_nxt;
      rx_bits_r   <= rx_bits_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      prefix_r    <= prefix_nxt;
      ack_r       <= ack_nxt;
      tx_bits_r   <= tx_bits_nxt;
      tx_pos_r    <= tx_pos_nxt;
      tx_active_r <= tx_active_nxt;
      ovf_r       <= ovf_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      qcount_r    <= qcount_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload and queue entries
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {2'b00, ovf_nxt, tx_active_nxt, ack_nxt, res_valid, res_code,
                     res_action};
    end
    if (code_push) begin
      code_mem_r[tail_r] <= code_new;
    end
  end

endmodule

@@ tb/ps2_keyboard_host_link_checker.sv @@
`timescale 1ns / 1ps
// Checker for the PS/2 keyboard host link: watches the input, result and register
// channels, predicts every result beat and compares it field by field.
// Depends on p2k_pkg for commands, line actions, register indexes and special bytes.

module ps2_keyboard_host_link_checker
  import p2k_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // edge_time[31:0], data_level[32], send_byte[40:33], zeros
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // line_action[1:0], read_code[17:2], read_valid[18],
                                  // ack_seen[19], tx_busy[20], overflow[21], zeros
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Prefix flag bits and flag bits of a queued code
  localparam int PFX_E0      = 0;
  localparam int PFX_E1      = 1;
  localparam int PFX_F0      = 2;
  localparam int CODE_E0_BIT = 8;
  localparam int CODE_E1_BIT = 9;
  localparam int CODE_BREAK  = 15;

  typedef struct packed {
    logic [1:0]  line_action;
    logic [15:0] read_code;
    logic        read_valid;
    logic        ack_seen;
    logic        tx_busy;
    logic        overflow;
  } link_status_t;

  // Own copy of the link state and its two timing registers
  logic [31:0]  glitch_gap_q;
  logic [31:0]  frame_timeout_q;
  logic [31:0]  last_edge;
  logic [10:0]  rx_bits;
  logic [3:0]   rx_count;
  logic [2:0]   prefix;
  logic         ack_flag;
  logic [8:0]   tx_bits;
  logic [3:0]   tx_pos;
  logic         tx_on;
  logic [15:0]  code_store [QUEUE_DEPTH];
  int           head;
  int           tail;
  int           count;
  logic         ovf_flag;

  link_status_t awaited_results [$];
  link_status_t predicted;
  link_status_t oldest;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
    $display("[%0t] link mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want,
             seen);
    fail_count++;
  endtask

  // Decode a complete receive frame: prefixes, acknowledge or a queued code
  task automatic take_frame();
    logic [15:0] code;
    if (rx_bits[0] || !rx_bits[10] || !(^rx_bits[9:1]))
      return;
    code = {8'h00, rx_bits[8:1]};
    case (rx_bits[8:1])
      BYTE_E0:  prefix[PFX_E0] = 1'b1;
      BYTE_E1:  prefix[PFX_E1] = 1'b1;
      BYTE_F0:  prefix[PFX_F0] = 1'b1;
      BYTE_ACK: ack_flag = 1'b1;
      default: begin
        if (prefix[PFX_E0])
          code[CODE_E0_BIT] = 1'b1;
        else if (prefix[PFX_E1])
          code[CODE_E1_BIT] = 1'b1;
        if (prefix[PFX_F0])
          code[CODE_BREAK] = 1'b1;
        // Drop the code on a full queue and remember it
        if (count >= QUEUE_DEPTH) begin
          ovf_flag = 1'b1;
        end else begin
          code_store[tail] = code;
          tail = (tail + 1) % QUEUE_DEPTH;
          count++;
        end
        prefix = '0;
      end
    endcase
  endtask

  // Advance the predicted link by one input beat and work out its result
  task automatic advance_host_link(input logic [1:0] cmd, input logic [31:0] stamp,
                                   input logic level, input logic [7:0] tx_byte,
                                   output link_status_t res);
    logic [31:0] gap;
    res = '0;
    case (cmd)
      CMD_EDGE: begin
        gap = stamp - last_edge;
        if (gap >= glitch_gap_q) begin
          if (gap > frame_timeout_q) begin
            rx_bits  = '0;
            rx_count = '0;
          end
          last_edge = stamp;
          if (tx_on) begin
            if (tx_pos >= TX_LAST_POS) begin
              tx_on           = 1'b0;
              tx_bits         = '0;
              tx_pos          = '0;
              res.line_action = LINE_RELEASE;
            end else begin
              res.line_action = tx_bits[tx_pos] ? LINE_HIGH : LINE_LOW;
              tx_pos++;
            end
          end else begin
            if (level)
              rx_bits[rx_count] = 1'b1;
            rx_count++;
            if (rx_count >= RX_FRAME_LEN) begin
              take_frame();
              rx_bits  = '0;
              rx_count = '0;
            end
          end
        end
      end
      CMD_READ: begin
        if (count > 0) begin
          res.read_code  = code_store[head];
          res.read_valid = 1'b1;
          head = (head + 1) % QUEUE_DEPTH;
          count--;
        end
      end
      CMD_SEND: begin
        tx_bits  = {~^tx_byte, tx_byte};
        tx_pos   = '0;
        tx_on    = 1'b1;
        ack_flag = 1'b0;
      end
      default: ;
    endcase
    res.ack_seen = ack_flag;
    res.tx_busy  = tx_on;
    res.overflow = ovf_flag;
  endtask

  // Follow every beat on the three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      glitch_gap_q    = GLITCH_GAP_RESET;
      frame_timeout_q = FRAME_TIMEOUT_RESET;
      last_edge       = '0;
      rx_bits         = '0;
      rx_count        = '0;
      prefix          = '0;
      ack_flag        = 1'b0;
      tx_bits         = '0;
      tx_pos          = '0;
      tx_on           = 1'b0;
      head            = 0;
      tail            = 0;
      count           = 0;
      ovf_flag        = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GLITCH_GAP)
          glitch_gap_q = cfg_data;
        else
          frame_timeout_q = cfg_data;
      end

      if (in_tvalid && in_tready) begin
        advance_host_link(in_tuser, in_tdata[31:0], in_tdata[32], in_tdata[40:33],
                          predicted);
        awaited_results.push_back(predicted);
      end

      // Compare each result beat with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing awaited", '0, 32'(out_tdata));
        end else begin
          oldest = awaited_results.pop_front();
          if (out_tdata[1:0] !== oldest.line_action)
            report_mismatch("line_action", 32'(oldest.line_action), 32'(out_tdata[1:0]));
          if (out_tdata[17:2] !== oldest.read_code)
            report_mismatch("read_code", 32'(oldest.read_code), 32'(out_tdata[17:2]));
          if (out_tdata[18] !== oldest.read_valid)
            report_mismatch("read_valid", 32'(oldest.read_valid), 32'(out_tdata[18]));
          if (out_tdata[19] !== oldest.ack_seen)
            report_mismatch("ack_seen", 32'(oldest.ack_seen), 32'(out_tdata[19]));
          if (out_tdata[20] !== oldest.tx_busy)
            report_mismatch("tx_busy", 32'(oldest.tx_busy), 32'(out_tdata[20]));
          if (out_tdata[21] !== oldest.overflow)
            report_mismatch("overflow", 32'(oldest.overflow), 32'(out_tdata[21]));
        end
      end
    end
    pending <= awaited_results.size();
  end

endmodule

@@ tb/ps2_keyboard_host_link_tb.sv @@
`timescale 1ns / 1ps
// Top of the PS/2 keyboard host link testbench: clock, reset, register writes, stimulus
// and the verdict. Depends on p2k_pkg, ps2_keyboard_host_link and the link checker.

module ps2_keyboard_host_link_tb;
  import p2k_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_BEAT   = 300;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int TX_EDGES         = TX_LAST_POS + 1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;

  // Stimulus-side view of timing registers and of the last edge the link took
  logic [31:0] glitch_now  = GLITCH_GAP_RESET;
  logic [31:0] timeout_now = FRAME_TIMEOUT_RESET;
  logic [31:0] last_taken  = '0;
  int          fed_items   = 0;
  int          feeds       = 0;
  bit          in_quick    = 1'b0;
  int          cycle_count = 0;

  ps2_keyboard_host_link dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ps2_keyboard_host_link_checker link_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("link testbench timed out after %0d cycles", CYCLE_LIMIT);
      $display("** ps2_keyboard_host_link: FAILED **");
      $finish;
    end
  end

  // Offer one input beat after a random pause and hold it until taken
  task automatic feed(input logic [1:0] cmd, input logic [31:0] stamp, input logic level,
                      input logic [7:0] byte_val, input bit counted);
    int idle;
    if (feeds % 32 == 0)
      in_quick = ($urandom_range(3, 0) == 0);
    feeds++;
    idle = in_quick ? 0 : $urandom_range(17, 0);
    repeat (idle) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, byte_val, level, stamp};
    do @(posedge clk); while (!in_tready);
    if (counted)
      fed_items++;
  endtask

  task automatic edge_stamp(input logic [31:0] stamp, input logic level);
    bit taken;
    taken = (stamp - last_taken) >= glitch_now;
    if (taken)
      last_taken = stamp;
    feed(CMD_EDGE, stamp, level, 8'($urandom), taken);
  endtask

  task automatic edge_gap(input logic [31:0] gap, input logic level);
    edge_stamp(last_taken + gap, level);
  endtask

  // Spacing inside a frame: the bounds themselves now and then
  function automatic logic [31:0] good_gap();
    logic [31:0] span;
    if (glitch_now > timeout_now)
      return glitch_now;
    span = timeout_now - glitch_now;
    case ($urandom_range(7, 0))
      0:       return glitch_now;
      1:       return timeout_now;
      default: return glitch_now + $urandom_range(span > 20000 ? 20000 : span, 0);
    endcase
  endfunction

  // Spacing that restarts a partial frame, where the timeout allows one
  function automatic logic [31:0] restart_gap();
    logic [31:0] lo;
    if (timeout_now == 32'hFFFF_FFFF)
      return good_gap();
    lo = timeout_now + 1;
    if (lo < glitch_now)
      lo = glitch_now;
    if (lo > 32'hFFFF_FF00)
      return lo;
    return lo + $urandom_range(100, 0);
  endfunction

  function automatic logic [10:0] frame_of(input logic [7:0] scan);
    return {1'b1, ~^scan, scan, 1'b0};
  endfunction

  // Clock out frame bits, with the odd glitch edge in between
  task automatic send_frame(input logic [10:0] bits, input int len);
    for (int i = 0; i < len; i++) begin
      if (glitch_now != 0 && $urandom_range(9, 0) == 0)
        edge_gap($urandom_range(glitch_now - 1, 0), 1'($urandom_range(1, 0)));
      edge_gap(i == 0 ? restart_gap() : good_gap(), bits[i]);
    end
  endtask

  task automatic key_seq();
    if ($urandom_range(4, 0) == 0)
      send_frame(frame_of(BYTE_E0), RX_FRAME_LEN);
    if ($urandom_range(9, 0) == 0)
      send_frame(frame_of(BYTE_E1), RX_FRAME_LEN);
    if ($urandom_range(2, 0) == 0)
      send_frame(frame_of(BYTE_F0), RX_FRAME_LEN);
    send_frame(frame_of($urandom_range(11, 0) == 0 ? BYTE_ACK : 8'($urandom)), RX_FRAME_LEN);
  endtask

  task automatic read_burst();
    int n;
    n = ($urandom_range(4, 0) == 0) ? $urandom_range(20, 1) : $urandom_range(3, 1);
    repeat (n) feed(CMD_READ, $urandom, 1'($urandom_range(1, 0)), 8'($urandom), 1'b1);
  endtask

  // Start a byte, maybe restart it part way, then clock it out
  task automatic transmit_seq(input bit clean);
    int edges;
    feed(CMD_SEND, $urandom, 1'($urandom_range(1, 0)), 8'($urandom), 1'b1);
    if ($urandom_range(4, 0) == 0) begin
      repeat ($urandom_range(4, 1)) edge_gap(good_gap(), 1'($urandom_range(1, 0)));
      feed(CMD_SEND, $urandom, 1'($urandom_range(1, 0)), 8'($urandom), 1'b1);
    end
    edges = TX_EDGES;
    if (!clean && $urandom_range(3, 0) == 0)
      edges = $urandom_range(12, 6);
    repeat (edges)
      edge_gap($urandom_range(5, 0) == 0 ? restart_gap() : good_gap(),
               1'($urandom_range(1, 0)));
  endtask

  // Corrupt one bit of a frame, or cut it short
  task automatic broken_frame(input bit clean);
    logic [10:0] bits;
    int          cut;
    bits = frame_of(8'($urandom));
    if (clean || $urandom_range(1, 0) == 0) begin
      cut = $urandom_range(10, 0);
      bits[cut] = ~bits[cut];
      send_frame(bits, RX_FRAME_LEN);
    end else begin
      send_frame(bits, $urandom_range(10, 1));
    end
  endtask

  task automatic noise_item();
    logic [1:0]  cmd;
    logic [31:0] stamp;
    cmd   = 2'($urandom_range(3, 0));
    stamp = $urandom_range(1, 0) ? 32'($urandom) : last_taken + good_gap();
    if (cmd == CMD_EDGE)
      edge_stamp(stamp, 1'($urandom_range(1, 0)));
    else
      feed(cmd, stamp, 1'($urandom_range(1, 0)), 8'($urandom), cmd != CMD_UNUSED);
  endtask

  // Mostly well-formed traffic; a clean mix keeps every frame whole
  task automatic traffic_mix(input int target, input bit clean);
    int pick;
    while (fed_items < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 45)
        key_seq();
      else if (pick < 60)
        read_burst();
      else if (pick < 72)
        transmit_seq(clean);
      else if (pick < 86)
        broken_frame(clean);
      else if (!clean)
        noise_item();
    end
  endtask

  // Fill the code queue past its depth, then drain it
  task automatic fill_queue();
    transmit_seq(1'b1);
    repeat (24) send_frame(frame_of(8'($urandom)), RX_FRAME_LEN);
    repeat (24) feed(CMD_READ, $urandom, 1'($urandom_range(1, 0)), 8'($urandom), 1'b1);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_GLITCH_GAP)
      glitch_now = value;
    else
      timeout_now = value;
  endtask

  task automatic set_timing(input logic [31:0] gap, input logic [31:0] timeout);
    write_reg(REG_GLITCH_GAP, gap);
    write_reg(REG_FRAME_TIMEOUT, timeout);
  endtask

  // Drop valid and wait until every awaited result has come back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Result side: random stalls, quick stretches and one long hold-off
  initial begin : result_sink
    int stall;
    int beats;
    bit out_quick;
    beats      = 0;
    out_quick  = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (beats % 32 == 0)
        out_quick = ($urandom_range(3, 0) == 0);
      stall = out_quick ? 0 : $urandom_range(17, 0);
      if (beats == LONG_HOLD_BEAT)
        stall = LONG_HOLD_CYCLES;
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      beats++;
    end
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_EDGE;
    cfg_valid = 1'b0;
    cfg_index = REG_GLITCH_GAP;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: unused command, empty read, edge time extremes, glitch bounds
    feed(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0);
    feed(CMD_READ, 32'h0, 1'b0, 8'h00, 1'b1);
    edge_stamp(32'h0, 1'b1);
    edge_stamp(32'hFFFF_FFFF, 1'b0);
    feed(CMD_SEND, 32'h0, 1'b0, 8'hFF, 1'b1);
    edge_gap(glitch_now, 1'b1);
    edge_gap(glitch_now - 1, 1'b0);
    // Restart transmit while busy, with a timeout gap in the middle of it
    feed(CMD_SEND, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b1);
    repeat (3) edge_gap(timeout_now, 1'b1);
    edge_gap(timeout_now + 1, 1'b0);
    repeat (TX_EDGES - 4) edge_gap(timeout_now, 1'b1);
    edge_gap(glitch_now, 1'b1);

    // Reset timing, then leave transmit idle and the frame aligned
    traffic_mix(fed_items + 150, 1'b0);
    transmit_seq(1'b1);
    send_frame(frame_of(8'h1C), RX_FRAME_LEN);
    settle();

    // No glitch filter and no timeout
    set_timing(32'h0, 32'hFFFF_FFFF);
    traffic_mix(fed_items + 100, 1'b1);
    settle();

    // Widest filter, zero timeout: every taken edge restarts the frame
    set_timing(32'hFFFF_FFFF, 32'h0);
    traffic_mix(fed_items + 60, 1'b0);
    settle();

    // Tight timing for the bulk of the run
    set_timing(32'd3, 32'd50);
    fill_queue();
    traffic_mix(fed_items + 150, 1'b0);
    settle();

    // Filter and timeout equal
    set_timing(32'd1000, 32'd1000);
    transmit_seq(1'b1);
    traffic_mix(fed_items + 100, 1'b0);
    settle();
    repeat (20) @(negedge clk);

    if (fail_count == 0)
      $display("** ps2_keyboard_host_link: PASSED **");
    else
      $display("** ps2_keyboard_host_link: FAILED **");
    $finish;
  end

endmodule
